[hw/rtl/ctiu_pkg.sv]
// Package for the calibration table interpolator.
// Holds sizes, codes, the controller state type and the command/status structs.
// No dependencies.
package ctiu_pkg;

   localparam int MAX_POINTS  = 64;
   localparam int PT_ADDR_W   = 6;
   localparam int NSP_W       = 7;
   localparam int CNT_W       = 10;
   localparam int HUM_W       = 14;
   localparam int RES_W       = 16;

   localparam int DIV_N_W     = 25;
   localparam int DIV_D_W     = 10;
   localparam int DIV_STEPS   = 25;
   localparam int DIV_CNT_W   = 5;

   // floor(x / 10) == (x * TEN_RECIP) >> TEN_SHIFT for every DIV_N_W-bit x
   localparam int TEN_RECIP_W = 26;
   localparam int TEN_SHIFT   = 29;
   localparam int TEN_PROD_W  = DIV_N_W + TEN_RECIP_W;
   localparam int TEN_Q_W     = TEN_PROD_W - TEN_SHIFT;

   localparam logic             REQ_LOAD    = 1'b0;
   localparam logic             REQ_CONVERT = 1'b1;
   localparam logic [TEN_RECIP_W-1:0] TEN_RECIP = TEN_RECIP_W'(53687092);
   localparam logic [RES_W-1:0]   RES_SAT   = {RES_W{1'b1}};

   typedef struct packed {
      logic [CNT_W-1:0] counts;
      logic [HUM_W-1:0] humidity;
   } point_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_READ,
      S_SCAN,
      S_READ_NEXT,
      S_MUL,
      S_DIV_PROD,
      S_WAIT_PROD,
      S_TEN_EXACT,
      S_TEN_SUM,
      S_CLAMP,
      S_DONE
   } ctl_state_type;

   typedef struct packed {
      logic scan_init;
      logic rd_en;
      logic step;
      logic mul;
      logic div_prod;
      logic sum_latch;
      logic ten_exact;
      logic ten_sum;
      logic res_load;
      logic res_clear;
   } ctiu_cmd_type;

   typedef struct packed {
      logic few;
      logic hit;
      logic exact;
      logic last;
      logic idx_zero;
      logic pair_equal;
      logic div_done;
   } ctiu_sts_type;

endpackage

[hw/rtl/calibration_table_interpolator_unit.sv]
// Top level of the calibration table interpolator: controller plus datapath.
// Depends on ctiu_pkg, ctiu_ctrl and ctiu_datapath.
//
// A load item (req_type 0) writes one table point in the cycle it is accepted and
// gives no result; busy stays low. A convert item (req_type 1) scans up to 64 table
// points one at a time through one registered memory read port. The divide by ten is
// a reciprocal multiply; an exact hit needs nothing else, otherwise a 25-step serial
// divide first forms the slope term. Two points that share a count, and fewer than
// two points in use, give a result of zero. busy is high from the accepting edge
// through the result cycle, so the next item can be taken in the cycle after it.
// The result appears on rsp_humidity_x10 with rsp_strobe high for exactly one cycle
// and cannot be held off. csr_write_data sets the number of points in use; write it
// only while busy is low.
module calibration_table_interpolator_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic                             req_type,
   input  logic [ctiu_pkg::PT_ADDR_W-1:0]   req_entry_index,
   input  logic [ctiu_pkg::CNT_W-1:0]       req_entry_counts,
   input  logic [ctiu_pkg::HUM_W-1:0]       req_entry_humidity,
   input  logic [ctiu_pkg::CNT_W-1:0]       req_sample_counts,
   output logic                             rsp_strobe,
   output logic [ctiu_pkg::RES_W-1:0]       rsp_humidity_x10,
   input  logic                             csr_write_enable,
   input  logic [ctiu_pkg::NSP_W-1:0]       csr_write_data
);
   import ctiu_pkg::*;

   ctiu_cmd_type cmd;
   ctiu_sts_type sts;
   logic         accept;
   logic         ctl_busy;

   assign accept = start & ~ctl_busy;
   assign busy   = ctl_busy;

   ctiu_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .accept_convert (accept & (req_type == REQ_CONVERT)),
      .sts            (sts),
      .cmd            (cmd),
      .busy           (ctl_busy),
      .strobe         (rsp_strobe)
   );

   ctiu_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .load_we        (accept & (req_type == REQ_LOAD)),
      .entry_index    (req_entry_index),
      .entry_counts   (req_entry_counts),
      .entry_humidity (req_entry_humidity),
      .sample_counts  (req_sample_counts),
      .csr_we         (csr_write_enable),
      .csr_data       (csr_write_data),
      .humidity_x10   (rsp_humidity_x10)
   );

endmodule

[hw/rtl/ctiu_div.sv]
// Serial restoring divider, one quotient bit per cycle, unsigned operands.
// Depends on ctiu_pkg.
module ctiu_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [ctiu_pkg::DIV_N_W-1:0]   dividend,
   input  logic [ctiu_pkg::DIV_D_W-1:0]   divisor,
   output logic                           done,
   output logic [ctiu_pkg::DIV_N_W-1:0]   quotient
);
   import ctiu_pkg::*;

   logic                 run_ff, run_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_N_W-1:0]   quo_ff, quo_in;
   logic [DIV_D_W-1:0]   rem_ff, rem_in;
   logic [DIV_D_W-1:0]   dvs_ff, dvs_in;
   logic [DIV_D_W:0]     rem_sh;
   logic                 fits;

   assign rem_sh = {rem_ff, quo_ff[DIV_N_W-1]};
   assign fits   = rem_sh >= {1'b0, dvs_ff};

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = DIV_CNT_W'(DIV_STEPS - 1);
         quo_in = dividend;
         rem_in = '0;
         dvs_in = divisor;
      end else if (run_ff) begin
         quo_in = {quo_ff[DIV_N_W-2:0], fits};
         rem_in = fits ? DIV_D_W'(rem_sh - {1'b0, dvs_ff}) : rem_sh[DIV_D_W-1:0];
         cnt_in = cnt_ff - DIV_CNT_W'(1);
         if (cnt_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

[hw/rtl/ctiu_datapath.sv]
// Datapath: point table memory, scan registers, multiplier, divider, divide-by-ten
// reciprocal multiply and result register. Depends on ctiu_pkg and ctiu_div.
module ctiu_datapath (
   input  logic                             clock,
   input  logic                             reset,
   input  ctiu_pkg::ctiu_cmd_type           cmd,
   output ctiu_pkg::ctiu_sts_type           sts,
   input  logic                             load_we,
   input  logic [ctiu_pkg::PT_ADDR_W-1:0]   entry_index,
   input  logic [ctiu_pkg::CNT_W-1:0]       entry_counts,
   input  logic [ctiu_pkg::HUM_W-1:0]       entry_humidity,
   input  logic [ctiu_pkg::CNT_W-1:0]       sample_counts,
   input  logic                             csr_we,
   input  logic [ctiu_pkg::NSP_W-1:0]       csr_data,
   output logic [ctiu_pkg::RES_W-1:0]       humidity_x10
);
   import ctiu_pkg::*;

   point_type pt_mem_ff [MAX_POINTS];
   point_type rd_data_ff;

   logic [NSP_W-1:0]     nsp_ff, nsp_in;
   logic [NSP_W-1:0]     nsp_eff;
   logic [CNT_W-1:0]     sample_ff, sample_in;
   logic [PT_ADDR_W-1:0] idx_ff, idx_in;
   point_type            prev_ff, prev_in;
   logic signed [25:0]   prod_ff, prod_in;
   logic signed [10:0]   dc_ff, dc_in;
   logic                 q_neg_ff, q_neg_in;
   logic signed [25:0]   sum_ff, sum_in;
   logic                 res_neg_ff, res_neg_in;
   logic [TEN_Q_W-1:0]   ten_q_ff, ten_q_in;
   logic [RES_W-1:0]     res_ff, res_in;

   logic signed [10:0]   ds;
   logic signed [14:0]   dh;
   logic [25:0]          prod_mag;
   logic [10:0]          dc_mag;
   logic [25:0]          sum_mag;
   logic signed [25:0]   q_s;
   logic [DIV_N_W-1:0]   ten_src;
   logic [TEN_PROD_W-1:0] ten_prod;

   logic                 div_start;
   logic [DIV_N_W-1:0]   div_dividend;
   logic [DIV_D_W-1:0]   div_divisor;
   logic                 div_done;
   logic [DIV_N_W-1:0]   div_q;

   always_ff @(posedge clock) begin
      if (load_we) begin
         pt_mem_ff[entry_index] <= '{counts: entry_counts, humidity: entry_humidity};
      end
      if (cmd.rd_en) begin
         rd_data_ff <= pt_mem_ff[idx_ff];
      end
   end

   assign nsp_eff = (nsp_ff > NSP_W'(MAX_POINTS)) ? NSP_W'(MAX_POINTS) : nsp_ff;

   assign sts.few        = nsp_eff < NSP_W'(2);
   assign sts.hit        = sample_ff <= rd_data_ff.counts;
   assign sts.exact      = sample_ff == rd_data_ff.counts;
   assign sts.last       = {1'b0, idx_ff} == (nsp_eff - NSP_W'(1));
   assign sts.idx_zero   = idx_ff == '0;
   assign sts.pair_equal = prev_ff.counts == rd_data_ff.counts;
   assign sts.div_done   = div_done;

   assign ds = $signed({1'b0, sample_ff}) - $signed({1'b0, prev_ff.counts});
   assign dh = $signed({1'b0, rd_data_ff.humidity}) - $signed({1'b0, prev_ff.humidity});

   assign prod_mag = prod_ff[25] ? 26'(-prod_ff) : prod_ff;
   assign dc_mag   = dc_ff[10] ? 11'(-dc_ff) : dc_ff;
   assign sum_mag  = sum_ff[25] ? 26'(-sum_ff) : sum_ff;
   assign q_s      = q_neg_ff ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});

   assign ten_src  = cmd.ten_sum ? sum_mag[DIV_N_W-1:0]
                                 : {{(DIV_N_W-HUM_W){1'b0}}, rd_data_ff.humidity};
   assign ten_prod = TEN_PROD_W'(ten_src) * TEN_PROD_W'(TEN_RECIP);

   always_comb begin
      nsp_in     = csr_we ? csr_data : nsp_ff;
      sample_in  = sample_ff;
      idx_in     = idx_ff;
      prev_in    = prev_ff;
      prod_in    = prod_ff;
      dc_in      = dc_ff;
      q_neg_in   = q_neg_ff;
      sum_in     = sum_ff;
      res_neg_in = res_neg_ff;
      ten_q_in   = ten_q_ff;
      res_in     = res_ff;
      if (cmd.scan_init) begin
         sample_in = sample_counts;
         idx_in    = '0;
      end
      if (cmd.step) begin
         prev_in = rd_data_ff;
         idx_in  = idx_ff + PT_ADDR_W'(1);
      end
      if (cmd.mul) begin
         prod_in = 26'(ds) * 26'(dh);
         dc_in   = $signed({1'b0, rd_data_ff.counts}) - $signed({1'b0, prev_ff.counts});
      end
      if (cmd.div_prod) begin
         q_neg_in = prod_ff[25] ^ dc_ff[10];
      end
      if (cmd.sum_latch) begin
         sum_in = q_s + $signed({12'b0, prev_ff.humidity});
      end
      if (cmd.ten_exact) begin
         res_neg_in = 1'b0;
      end
      if (cmd.ten_sum) begin
         res_neg_in = sum_ff[25];
      end
      if (cmd.ten_exact | cmd.ten_sum) begin
         ten_q_in = ten_prod[TEN_SHIFT +: TEN_Q_W];
      end
      if (cmd.res_clear) begin
         res_in = '0;
      end else if (cmd.res_load) begin
         if (res_neg_ff) begin
            res_in = '0;
         end else if (ten_q_ff > TEN_Q_W'(RES_SAT)) begin
            res_in = RES_SAT;
         end else begin
            res_in = ten_q_ff[RES_W-1:0];
         end
      end
   end

   assign div_start    = cmd.div_prod;
   assign div_dividend = prod_mag[DIV_N_W-1:0];
   assign div_divisor  = dc_mag[DIV_D_W-1:0];

   ctiu_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         nsp_ff <= '0;
      end else begin
         nsp_ff <= nsp_in;
      end
      sample_ff  <= sample_in;
      idx_ff     <= idx_in;
      prev_ff    <= prev_in;
      prod_ff    <= prod_in;
      dc_ff      <= dc_in;
      q_neg_ff   <= q_neg_in;
      sum_ff     <= sum_in;
      res_neg_ff <= res_neg_in;
      ten_q_ff   <= ten_q_in;
      res_ff     <= res_in;
   end

   assign humidity_x10 = res_ff;

endmodule

[hw/rtl/ctiu_ctrl.sv]
// Controller state machine: table scan, interpolation, divide and scaling sequencing.
// Depends on ctiu_pkg.
module ctiu_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    accept_convert,
   input  ctiu_pkg::ctiu_sts_type  sts,
   output ctiu_pkg::ctiu_cmd_type  cmd,
   output logic                    busy,
   output logic                    strobe
);
   import ctiu_pkg::*;

   ctl_state_type state_ff, state_in;
   logic          found;

   assign found = sts.hit | sts.last;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept_convert) begin
               state_in = sts.few ? S_DONE : S_READ;
            end
         end
         S_READ: state_in = S_SCAN;
         S_SCAN: begin
            if (!found) begin
               state_in = S_READ;
            end else if (sts.exact) begin
               state_in = S_TEN_EXACT;
            end else if (sts.idx_zero) begin
               state_in = S_READ_NEXT;
            end else begin
               state_in = S_MUL;
            end
         end
         S_READ_NEXT: state_in = S_MUL;
         S_MUL: state_in = sts.pair_equal ? S_DONE : S_DIV_PROD;
         S_DIV_PROD: state_in = S_WAIT_PROD;
         S_WAIT_PROD: begin
            if (sts.div_done) begin
               state_in = S_TEN_SUM;
            end
         end
         S_TEN_EXACT: state_in = S_CLAMP;
         S_TEN_SUM: state_in = S_CLAMP;
         S_CLAMP: state_in = S_DONE;
         S_DONE: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd    = '0;
      busy   = 1'b1;
      strobe = 1'b0;
      case (state_ff)
         S_IDLE: begin
            busy          = 1'b0;
            cmd.scan_init = accept_convert;
            cmd.res_clear = accept_convert & sts.few;
         end
         S_READ: cmd.rd_en = 1'b1;
         S_SCAN: cmd.step = !found || (!sts.exact && sts.idx_zero);
         S_READ_NEXT: cmd.rd_en = 1'b1;
         S_MUL: begin
            cmd.mul       = 1'b1;
            cmd.res_clear = sts.pair_equal;
         end
         S_DIV_PROD: cmd.div_prod = 1'b1;
         S_WAIT_PROD: cmd.sum_latch = sts.div_done;
         S_TEN_EXACT: cmd.ten_exact = 1'b1;
         S_TEN_SUM: cmd.ten_sum = 1'b1;
         S_CLAMP: cmd.res_load = 1'b1;
         S_DONE: strobe = 1'b1;
         default: busy = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
